// File: rtl/mvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared widths, codes and defaults of the matrix-vector multiply unit.
// ----------------------------------------------------------------------------
package mvm_pkg;

	// Parameter defaults
	localparam int unsigned DEF_MAX_COLS   = 256;
	localparam int unsigned DEF_DATA_WIDTH = 16;

	// Fixed field widths
	localparam int unsigned COL_W     = 8;   // column field of a load word
	localparam int unsigned ACC_W     = 40;  // row sum and accumulator
	localparam int unsigned ROW_W     = 16;  // row index and row counter
	localparam int unsigned COLCNT_W  = 9;   // col_count register
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 16;

	// Opcodes carried on tuser
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_MATRIX = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

	// Register reset values
	localparam logic [COLCNT_W-1:0] COL_COUNT_RST = 9'd256;
	localparam logic [ROW_W-1:0]    ROW_COUNT_RST = 16'd1;

endpackage

// File: rtl/matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_unit
// Streaming fixed-point matrix times vector: loads fill a vector store,
// matrix elements are multiplied by the stored element of their column and
// summed exactly; one result word per finished row.
// ----------------------------------------------------------------------------
//  channel   | direction | words carried
//  ----------+-----------+--------------------------------------------------
//  s_*       | in        | tuser = opcode, tdata = column, value
//  m_*       | out       | tdata = row_sum, row_index; tlast = last_row
//  cfg_*     | in        | register index and write data
//
//  One input word per cycle while s_tready is high, loads and matrix elements alike.
//  A row result is written to the output register after the row's last
//  element passes store read, multiply, then accumulate.
//  No clearing pass after reset; the vector store is valid once written.
//  When the output register is full and not taken, the whole pipeline and
//  s_tready hold until m_tready is seen.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_unit #(
	parameter int unsigned MAX_COLS   = mvm_pkg::DEF_MAX_COLS,
	parameter int unsigned DATA_WIDTH = mvm_pkg::DEF_DATA_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input words
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// [7:0] column, [8+DATA_WIDTH-1:8] value, zero padded
	input  logic [((mvm_pkg::COL_W + DATA_WIDTH + 7) / 8) * 8 - 1 : 0] s_tdata,
	// [0] opcode
	input  logic                                   s_tuser,
	// result words
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [39:0] row_sum, [55:40] row_index
	output logic [mvm_pkg::ACC_W + mvm_pkg::ROW_W - 1 : 0] m_tdata,
	// last_row
	output logic                                   m_tlast,
	// register writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mvm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mvm_pkg::CFG_DAT_W-1:0]          cfg_data
);
	import mvm_pkg::*;

	localparam int unsigned CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned CMPW = (CW + 1 > COLCNT_W) ? CW + 1 : COLCNT_W;
	localparam int unsigned PW   = 2 * DATA_WIDTH;

	// configuration registers
	logic [COLCNT_W-1:0] col_count_q;
	logic [ROW_W-1:0]    row_count_q;

	// control state
	logic [CW-1:0]       col_cnt_q;
	logic [ROW_W-1:0]    row_cnt_q;
	logic signed [ACC_W-1:0] acc_q;

	// pipeline
	logic                          valid_s1, end_s1, last_s1;
	logic [ROW_W-1:0]              row_s1;
	logic signed [DATA_WIDTH-1:0]  value_s1, rd_s1;
	logic                          valid_s2, end_s2, last_s2;
	logic [ROW_W-1:0]              row_s2;
	logic signed [PW-1:0]          prod_s2;

	// output register
	logic                    out_valid_q;
	logic [ACC_W-1:0]        out_sum_q;
	logic [ROW_W-1:0]        out_row_q;
	logic                    out_last_q;

	// vector store
	logic [DATA_WIDTH-1:0]   vec_mem [MAX_COLS];

	// decoded input word
	logic [COL_W-1:0]              in_col;
	logic signed [DATA_WIDTH-1:0]  in_val;
	logic                          adv, accept, acc_mat, mem_we;
	logic [CMPW-1:0]               cols_eff, col_next;
	logic [ROW_W:0]                rows_eff, row_next;
	logic                          end_row, last_row;
	logic signed [ACC_W-1:0]       acc_sum;

	assign in_col = s_tdata[COL_W-1:0];
	assign in_val = s_tdata[COL_W +: DATA_WIDTH];

	// pipeline moves whenever the output register is free or being emptied
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;
	assign acc_mat  = accept && (s_tuser == OP_MATRIX);
	assign mem_we   = accept && (s_tuser == OP_LOAD)
		&& (CMPW'(in_col) < CMPW'(MAX_COLS));

	assign cfg_ready = 1'b1;

	// effective column and row counts
	always_comb begin
		if (col_count_q == '0) begin
			cols_eff = CMPW'(1);
		end else if (CMPW'(col_count_q) > CMPW'(MAX_COLS)) begin
			cols_eff = CMPW'(MAX_COLS);
		end else begin
			cols_eff = CMPW'(col_count_q);
		end
		rows_eff = (row_count_q == '0) ? (ROW_W+1)'(1) : {1'b0, row_count_q};
		col_next = CMPW'(col_cnt_q) + CMPW'(1);
		row_next = {1'b0, row_cnt_q} + (ROW_W+1)'(1);
		end_row  = (col_next >= cols_eff);
		last_row = (row_next >= rows_eff);
	end

	assign acc_sum = acc_q + ACC_W'(prod_s2);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= COL_COUNT_RST;
			row_count_q <= ROW_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COL_COUNT: col_count_q <= cfg_data[COLCNT_W-1:0];
				REG_ROW_COUNT: row_count_q <= cfg_data[ROW_W-1:0];
				default:       ;
			endcase
		end
	end

	// column and row counters, advanced per accepted matrix word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (acc_mat) begin
			if (end_row) begin
				col_cnt_q <= '0;
				row_cnt_q <= last_row ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_cnt_q <= col_next[CW-1:0];
			end
		end
	end

	// vector store: load writes and matrix reads share the accept cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vec_mem[CW'(in_col)] <= in_val;
		end
		if (adv) begin
			rd_s1 <= vec_mem[col_cnt_q];
		end
	end

	// pipeline valid bits and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else if (adv) begin
			valid_s1    <= acc_mat;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 && end_s2;
			if (valid_s2) begin
				acc_q <= end_s2 ? '0 : acc_sum;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			value_s1 <= in_val;
			end_s1   <= end_row;
			last_s1  <= last_row;
			row_s1   <= row_cnt_q;
			prod_s2  <= value_s1 * rd_s1;
			end_s2   <= end_s1;
			last_s2  <= last_s1;
			row_s2   <= row_s1;
			if (valid_s2 && end_s2) begin
				out_sum_q  <= acc_sum;
				out_row_q  <= row_s2;
				out_last_q <= last_s2;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_row_q, out_sum_q};
	assign m_tlast  = out_last_q;

	// checks
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(col_cnt_q) < CMPW'(MAX_COLS))
		else $error("column counter beyond store depth");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s2 && end_s2 |=> acc_q == '0)
		else $error("accumulator not cleared after row end");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc_mat && end_row && last_row |=> row_cnt_q == '0)
		else $error("row counter not returned after final row");

	a_load_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == OP_LOAD |=> !valid_s1)
		else $error("load word entered the multiply pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(acc_q) && valid_s2 == $past(valid_s2))
		else $error("pipeline moved while output held");

endmodule
